// File: design/base64_stream_decoder_assert.svh
// ----------------------------------------------------------------------------
// Base64 stream decoder assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

// same-cycle implication
`define B64SD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define B64SD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/b64sd_pkg.sv
// ----------------------------------------------------------------------------
// Base64 stream decoder package
// Item types, queue sizes, character map and count helpers.
// ----------------------------------------------------------------------------
package b64sd_pkg;

    localparam int CNT_W = 24;                  // byte counter width, 8..64
    localparam int LEN_W = 24;
    localparam logic [LEN_W-1:0] LEN_MAX   = '1;
    localparam logic [LEN_W-1:0] CAP_RESET = LEN_MAX;

    // both depths are powers of two
    localparam int JOBQ_DEPTH = 4;
    localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);
    localparam int JOBQ_CW    = $clog2(JOBQ_DEPTH + 1);
    localparam int OUTQ_DEPTH = 2;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    localparam logic [7:0] MARK_INVALID = 8'h40;
    localparam logic [7:0] MARK_PAD     = 8'h80;

    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5a;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7a;
    localparam logic [7:0] CH_D0    = 8'h30;
    localparam logic [7:0] CH_D9    = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_EQ    = 8'h3d;

    localparam logic [7:0] SX_LOWER = 8'd26;
    localparam logic [7:0] SX_DIGIT = 8'h34;
    localparam logic [7:0] SX_PLUS  = 8'h3e;
    localparam logic [7:0] SX_SLASH = 8'h3f;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_only;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             byte_valid;
        logic             stream_done;
        logic             status_code;
        logic [LEN_W-1:0] total_len;
        logic             run_last;
    } t_out_item;

    // decoded quantum handed from front to back; bytes[0] goes out first
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      nbytes;
        logic            is_end;
        logic            err;
    } t_job;

    function automatic logic [7:0] map_char(logic [7:0] c);
        logic [7:0] v;
        v = MARK_INVALID;
        if (c >= CH_UA && c <= CH_UZ) begin
            v = c - CH_UA;
        end else if (c >= CH_LA && c <= CH_LZ) begin
            v = (c - CH_LA) + SX_LOWER;
        end else if (c >= CH_D0 && c <= CH_D9) begin
            v = (c - CH_D0) + SX_DIGIT;
        end else if (c == CH_PLUS) begin
            v = SX_PLUS;
        end else if (c == CH_SLASH) begin
            v = SX_SLASH;
        end else if (c == CH_EQ) begin
            v = MARK_PAD;
        end
        return v;
    endfunction

    function automatic logic [CNT_W-1:0] cnt_add(logic [CNT_W-1:0] c, logic [1:0] k);
        logic [CNT_W+1:0] s;
        s = (CNT_W+2)'(c) + (CNT_W+2)'(k);
        if (s[CNT_W+1:CNT_W] != 2'b00) begin
            return '1;
        end
        return s[CNT_W-1:0];
    endfunction

    function automatic logic cnt_below(logic [CNT_W-1:0] c, logic [LEN_W-1:0] cap);
        return (CNT_W+LEN_W)'(c) < (CNT_W+LEN_W)'(cap);
    endfunction

    function automatic logic [LEN_W-1:0] sat_len(logic [CNT_W-1:0] c);
        logic [CNT_W+LEN_W-1:0] t;
        t = (CNT_W+LEN_W)'(c);
        if (t > (CNT_W+LEN_W)'(LEN_MAX)) begin
            return LEN_MAX;
        end
        return t[LEN_W-1:0];
    endfunction

endpackage

// File: design/b64sd_front.sv
// ----------------------------------------------------------------------------
// Base64 decoder front end
// Maps characters, gathers quanta, checks padding and tracks the error flag.
// ----------------------------------------------------------------------------
module b64sd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  b64sd_pkg::t_in_item i_item,
    input  logic                i_q_full,
    output logic                o_full,
    output logic                o_job_push,
    output b64sd_pkg::t_job     o_job
);

    typedef struct packed {
        logic [1:0] nbytes;
        logic       err;
    } t_fin;

    function automatic t_fin finish(logic [7:0] a, logic [7:0] b,
                                    logic [7:0] c, logic [7:0] d);
        t_fin f;
        logic [7:0] v;
        v = a | b | c | d;
        f = '0;
        if ((v & b64sd_pkg::MARK_INVALID) != 8'h00) begin
            f.err = 1'b1;
        end else if ((v & b64sd_pkg::MARK_PAD) == 8'h00) begin
            f.nbytes = 2'd3;
        end else if (((a | b | c) & b64sd_pkg::MARK_PAD) == 8'h00) begin
            f.nbytes = 2'd2;
        end else if ((((a | b) & b64sd_pkg::MARK_PAD) == 8'h00) && c == d) begin
            f.nbytes = 2'd1;
        end else begin
            f.err = 1'b1;
        end
        return f;
    endfunction

    logic [1:0]      r_pos;
    logic [2:0][7:0] r_held;
    logic            r_err;

    logic [1:0]      n_pos;
    logic [2:0][7:0] n_held;
    logic            n_err;

    logic            accept;
    logic            is_end;
    logic            fin;
    logic [7:0]      sx;
    logic [7:0]      fa, fb, fc, fd;
    t_fin            dec;
    logic [1:0]      nbytes;

    assign o_full = i_q_full;
    assign accept = i_push && !i_q_full;
    assign is_end = i_item.end_only || i_item.last_char;
    assign sx     = b64sd_pkg::map_char(i_item.char_code);

    always_comb begin
        n_pos  = r_pos;
        n_held = r_held;
        fin    = 1'b0;
        fa     = r_held[0];
        fb     = r_held[1];
        fc     = r_held[2];
        fd     = sx;
        if (!i_item.end_only) begin
            if (r_pos != 2'd3) begin
                n_held[r_pos] = sx;
                n_pos         = r_pos + 2'd1;
            end else begin
                fin   = 1'b1;
                n_pos = 2'd0;
            end
        end
        // short final quantum: missing places count as pad
        if (is_end && n_pos != 2'd0) begin
            fin = 1'b1;
            fa  = n_held[0];
            fb  = (n_pos > 2'd1) ? n_held[1] : b64sd_pkg::MARK_PAD;
            fc  = (n_pos > 2'd2) ? n_held[2] : b64sd_pkg::MARK_PAD;
            fd  = b64sd_pkg::MARK_PAD;
        end
        dec    = finish(fa, fb, fc, fd);
        n_err  = r_err || (fin && dec.err);
        nbytes = (fin && !r_err) ? dec.nbytes : 2'd0;
    end

    always_comb begin
        o_job.bytes[0] = {fa[5:0], fb[5:4]};
        o_job.bytes[1] = {fb[3:0], fc[5:2]};
        o_job.bytes[2] = {fc[1:0], fd[5:0]};
        o_job.nbytes   = nbytes;
        o_job.is_end   = is_end;
        o_job.err      = n_err;
    end

    assign o_job_push = accept && (nbytes != 2'd0 || is_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 2'd0;
            r_held <= '0;
            r_err  <= 1'b0;
        end else if (accept) begin
            if (is_end) begin
                r_pos  <= 2'd0;
                r_held <= '0;
                r_err  <= 1'b0;
            end else begin
                r_pos  <= n_pos;
                r_held <= n_held;
                r_err  <= n_err;
            end
        end
    end

endmodule

// File: design/b64sd_jobq.sv
// ----------------------------------------------------------------------------
// Base64 decoder job queue
// Short queue of decoded quanta between front and back end.
// ----------------------------------------------------------------------------
module b64sd_jobq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  b64sd_pkg::t_job i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output b64sd_pkg::t_job o_job
);

    b64sd_pkg::t_job                   r_mem [b64sd_pkg::JOBQ_DEPTH];
    logic [b64sd_pkg::JOBQ_AW-1:0]     r_wp;
    logic [b64sd_pkg::JOBQ_AW-1:0]     r_rp;
    logic [b64sd_pkg::JOBQ_CW-1:0]     r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = r_cnt == b64sd_pkg::JOBQ_CW'(b64sd_pkg::JOBQ_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: design/b64sd_back.sv
// ----------------------------------------------------------------------------
// Base64 decoder back end
// Counts bytes against capacity, builds result items, queues them for output.
// ----------------------------------------------------------------------------
module b64sd_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_job_valid,
    input  b64sd_pkg::t_job                     i_job,
    output logic                                o_job_pop,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [b64sd_pkg::LEN_W-1:0]         i_cfg_data,
    input  logic                                i_pop,
    output logic                                o_empty,
    output b64sd_pkg::t_out_item                o_out_item
);

    logic [b64sd_pkg::LEN_W-1:0]   r_cap;
    logic [b64sd_pkg::CNT_W-1:0]   r_cnt;
    logic                          r_room;     // r_cnt below r_cap
    logic [1:0]                    r_slot;

    b64sd_pkg::t_out_item          r_oq [b64sd_pkg::OUTQ_DEPTH];
    logic [b64sd_pkg::OUTQ_AW-1:0] r_wp;
    logic [b64sd_pkg::OUTQ_AW-1:0] r_rp;
    logic [b64sd_pkg::OUTQ_CW-1:0] r_oc;

    logic [1:0]                    rem;
    logic [b64sd_pkg::CNT_W-1:0]   c1;
    logic [b64sd_pkg::CNT_W-1:0]   cr;
    logic [b64sd_pkg::CNT_W-1:0]   cnt_fin;
    logic                          room1;
    logic                          want;
    logic                          last;
    logic                          step;
    logic                          oq_full;
    logic                          oq_pop;
    b64sd_pkg::t_out_item          res;

    assign o_cfg_ready = 1'b1;

    assign rem   = i_job.nbytes - r_slot;
    assign c1    = b64sd_pkg::cnt_add(r_cnt, 2'd1);
    assign cr    = b64sd_pkg::cnt_add(r_cnt, rem);
    assign room1 = b64sd_pkg::cnt_below(c1, r_cap);

    always_comb begin
        want    = 1'b0;
        last    = 1'b0;
        cnt_fin = r_cnt;
        res     = '0;
        if (i_job.nbytes != 2'd0) begin
            if (r_room) begin
                want           = 1'b1;
                res.out_byte   = i_job.bytes[r_slot];
                res.byte_valid = 1'b1;
                last           = (rem == 2'd1) || !room1;
                cnt_fin        = room1 ? c1 : cr;
            end else begin
                // rest of the quantum is past capacity: count only
                want    = i_job.is_end;
                last    = 1'b1;
                cnt_fin = cr;
            end
        end else begin
            want = 1'b1;
            last = 1'b1;
        end
        if (last) begin
            res.run_last    = 1'b1;
            res.stream_done = i_job.is_end;
            res.status_code = i_job.is_end && i_job.err;
            if (i_job.is_end && !i_job.err) begin
                res.total_len = b64sd_pkg::sat_len(cnt_fin);
            end
        end
    end

    assign oq_full    = r_oc == b64sd_pkg::OUTQ_CW'(b64sd_pkg::OUTQ_DEPTH);
    assign o_empty    = r_oc == '0;
    assign o_out_item = r_oq[r_rp];
    assign oq_pop     = i_pop && !o_empty;
    assign step       = i_job_valid && (!want || !oq_full);
    assign o_job_pop  = step && last;

    always_ff @(posedge i_clk) begin
        if (step && want) begin
            r_oq[r_wp] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= b64sd_pkg::CAP_RESET;
            r_cnt  <= '0;
            r_room <= b64sd_pkg::CAP_RESET != '0;
            r_slot <= 2'd0;
        end else if (i_cfg_valid) begin
            r_cap  <= i_cfg_data;
            r_room <= b64sd_pkg::cnt_below(r_cnt, i_cfg_data);
        end else if (step) begin
            r_slot <= last ? 2'd0 : r_slot + 2'd1;
            if (last && i_job.is_end) begin
                r_cnt  <= '0;
                r_room <= r_cap != '0;
            end else begin
                r_cnt  <= cnt_fin;
                r_room <= room1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_oc <= '0;
        end else begin
            if (step && want) begin
                r_wp <= r_wp + 1'b1;
            end
            if (oq_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if ((step && want) && !oq_pop) begin
                r_oc <= r_oc + 1'b1;
            end else if (oq_pop && !(step && want)) begin
                r_oc <= r_oc - 1'b1;
            end
        end
    end

endmodule

// File: design/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// Base64 stream decoder
// Streaming base64 text decoder with capacity limit and end-of-text status.
// ----------------------------------------------------------------------------
// One character item is taken per clock while the four-entry job queue has
// room; a character that completes no quantum makes no result. The back end
// writes one result item per cycle into a two-entry output queue while that
// queue has room. A full quantum of four characters gives up to three result
// items. With both queues empty, an accepted item's quantum is registered
// in the job queue, then its first result in the output queue, whose head
// drives the ports.
// No clearing pass after reset; out_capacity is written through the cfg
// channel, which is always ready.
module base64_stream_decoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  b64sd_pkg::t_in_item         i_in_item,
    output logic                        empty,
    input  logic                        pop,
    output b64sd_pkg::t_out_item        o_out_item,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [b64sd_pkg::LEN_W-1:0] i_cfg_data
);

    logic            q_full;
    logic            job_push;
    b64sd_pkg::t_job job_in;
    logic            job_valid;
    b64sd_pkg::t_job job_head;
    logic            job_pop;

    b64sd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_in_item),
        .i_q_full   (q_full),
        .o_full     (full),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    b64sd_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (job_pop),
        .o_full  (q_full),
        .o_valid (job_valid),
        .o_job   (job_head)
    );

    b64sd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job_head),
        .o_job_pop   (job_pop),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_item  (o_out_item)
    );

endmodule

// File: design/b64sd_checker.sv
// ----------------------------------------------------------------------------
// Base64 stream decoder port checker
// Checks result item consistency on the top-level ports.
// ----------------------------------------------------------------------------
`include "base64_stream_decoder_assert.svh"

module b64sd_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        empty,
    input  logic                        pop,
    input  b64sd_pkg::t_out_item        o_out_item
);

    `B64SD_ASSERT_NOW(a_status_only_done, !empty && !o_out_item.byte_valid, o_out_item.stream_done && o_out_item.out_byte == 8'h00, "status-only item without end of text")

    `B64SD_ASSERT_NOW(a_done_is_last, !empty && o_out_item.stream_done, o_out_item.run_last, "end-of-text item not last of its run")

    `B64SD_ASSERT_NOW(a_status_quiet, !empty && !o_out_item.stream_done, !o_out_item.status_code && o_out_item.total_len == '0, "status fields set before end of text")

    `B64SD_ASSERT_NOW(a_error_empty, !empty && o_out_item.status_code, o_out_item.total_len == '0 && !o_out_item.byte_valid, "error status with length or byte")

    `B64SD_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(o_out_item), "waiting item changed")

endmodule

bind base64_stream_decoder b64sd_checker u_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 stream decoder testbench
// Feeds text one character item at a time through the push/full side and
// drains result items through the empty/pop side. A decoder model inside the
// bench tracks quantum position, held sextets, the sticky error and the byte
// count, and queues the result items each accepted item owes. A short table
// of directed items comes first. Random texts follow: clean, corrupted and
// noise, under several output capacities. Both sides idle at random, and one
// phase holds off the receiver long enough to stall the input.
// ----------------------------------------------------------------------------
module tb;

    localparam int LEN_W       = b64sd_pkg::LEN_W;
    localparam int CNT_W       = b64sd_pkg::CNT_W;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 50;
    localparam int NUM_PHASES  = 6;
    localparam int HOLD_PHASE  = 4;
    localparam int SETTLE      = 8;
    localparam int NUM_ROWS    = 25;

    typedef struct packed {
        b64sd_pkg::t_in_item  it;
        logic                 fixed;
        b64sd_pkg::t_out_item want;
    } t_dir_row;

    localparam b64sd_pkg::t_out_item DONE_OK  = '{8'h00, 1'b0, 1'b1, 1'b0, '0, 1'b1};
    localparam b64sd_pkg::t_out_item DONE_ERR = '{8'h00, 1'b0, 1'b1, 1'b1, '0, 1'b1};
    localparam b64sd_pkg::t_out_item NO_FIX   = '0;

    localparam t_dir_row DIR_TAB [NUM_ROWS] = '{
        '{'{8'hff, 1'b1, 1'b0}, 1'b1, DONE_OK},     // empty text right after reset
        '{'{"T",   1'b0, 1'b0}, 1'b0, NO_FIX},
        '{'{"W",   1'b0, 1'b0}, 1'b0, NO_FIX},
        '{'{"F",   1'b0, 1'b0}, 1'b0, NO_FIX},
        '{'{"u",   1'b0, 1'b1}, 1'b0, NO_FIX},
        '{'{"Q",   1'b0, 1'b0}, 1'b0, NO_FIX},      // double pad mid-stream
        '{'{"Q",   1'b0, 1'b0}, 1'b0, NO_FIX},
        '{'{b64sd_pkg::CH_EQ, 1'b0, 1'b0}, 1'b0, NO_FIX},
        '{'{b64sd_pkg::CH_EQ, 1'b0, 1'b0}, 1'b0, NO_FIX},
        '{'{b64sd_pkg::CH_PLUS,  1'b0, 1'b0}, 1'b0, NO_FIX},   // single pad mid-stream
        '{'{b64sd_pkg::CH_SLASH, 1'b0, 1'b0}, 1'b0, NO_FIX},
        '{'{b64sd_pkg::CH_D9, 1'b0, 1'b0}, 1'b0, NO_FIX},
        '{'{b64sd_pkg::CH_EQ, 1'b0, 1'b0}, 1'b0, NO_FIX},
        '{'{8'h00, 1'b1, 1'b1}, 1'b0, NO_FIX},
        '{'{8'h00, 1'b0, 1'b0}, 1'b0, NO_FIX},      // invalid char, still consumed
        '{'{"A",   1'b0, 1'b0}, 1'b0, NO_FIX},
        '{'{"A",   1'b0, 1'b0}, 1'b0, NO_FIX},
        '{'{"A",   1'b0, 1'b1}, 1'b1, DONE_ERR},
        '{'{"A",   1'b0, 1'b1}, 1'b1, DONE_ERR},    // lone leftover char
        '{'{"Z",   1'b0, 1'b0}, 1'b0, NO_FIX},      // implicit pad
        '{'{"m",   1'b0, 1'b0}, 1'b0, NO_FIX},
        '{'{b64sd_pkg::CH_D9, 1'b0, 1'b1}, 1'b0, NO_FIX},
        '{'{b64sd_pkg::CH_EQ, 1'b0, 1'b0}, 1'b0, NO_FIX},      // pad in leading places
        '{'{b64sd_pkg::CH_EQ, 1'b0, 1'b0}, 1'b0, NO_FIX},
        '{'{8'h00, 1'b1, 1'b0}, 1'b1, DONE_ERR}
    };

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 push        = 1'b0;
    logic                 full;
    b64sd_pkg::t_in_item  i_in_item   = '0;
    logic                 empty;
    logic                 pop         = 1'b0;
    b64sd_pkg::t_out_item o_out_item;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [LEN_W-1:0]     i_cfg_data  = '0;

    // decoder model state
    int unsigned          run_pos     = 0;
    logic [7:0]           run_held [3] = '{default: 8'h00};
    logic                 run_err     = 1'b0;
    logic [CNT_W-1:0]     run_cnt     = '0;
    logic [LEN_W-1:0]     cap_now     = b64sd_pkg::CAP_RESET;

    b64sd_pkg::t_out_item owed_q [$];
    b64sd_pkg::t_out_item step_out [$];
    logic [7:0]           text_q [$];

    int                   err_cnt     = 0;
    int                   items_sent  = 0;
    int unsigned          cycles      = 0;
    bit                   quiet       = 1'b0;
    bit                   hold_req    = 1'b0;
    bit                   hold_taken  = 1'b0;
    int                   hold_left   = 0;

    base64_stream_decoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (i_in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] sextet_of(logic [7:0] c);
        if (c >= b64sd_pkg::CH_UA && c <= b64sd_pkg::CH_UZ) return c - b64sd_pkg::CH_UA;
        if (c >= b64sd_pkg::CH_LA && c <= b64sd_pkg::CH_LZ)
            return c - b64sd_pkg::CH_LA + 8'd26;
        if (c >= b64sd_pkg::CH_D0 && c <= b64sd_pkg::CH_D9)
            return c - b64sd_pkg::CH_D0 + 8'd52;
        if (c == b64sd_pkg::CH_PLUS) return 8'd62;
        if (c == b64sd_pkg::CH_SLASH) return 8'd63;
        if (c == b64sd_pkg::CH_EQ) return b64sd_pkg::MARK_PAD;
        return b64sd_pkg::MARK_INVALID;
    endfunction

    function automatic logic [7:0] char_of(logic [5:0] s);
        if (s < 6'd26) return b64sd_pkg::CH_UA + 8'(s);
        if (s < 6'd52) return b64sd_pkg::CH_LA + 8'(s - 6'd26);
        if (s < 6'd62) return b64sd_pkg::CH_D0 + 8'(s - 6'd52);
        if (s == 6'd62) return b64sd_pkg::CH_PLUS;
        return b64sd_pkg::CH_SLASH;
    endfunction

    task automatic put_out(input logic [7:0] b, input logic v);
        b64sd_pkg::t_out_item r;
        r = '0;
        r.out_byte = b;
        r.byte_valid = v;
        step_out.push_back(r);
    endtask

    task automatic give_byte(input logic [7:0] b);
        if (run_cnt < cap_now) put_out(b, 1'b1);
        if (run_cnt != '1) run_cnt = run_cnt + CNT_W'(1);
    endtask

    task automatic close_quantum(input logic [7:0] a, input logic [7:0] b,
                                 input logic [7:0] c, input logic [7:0] d);
        logic [7:0] v;
        v = a | b | c | d;
        if (!run_err) begin
            if ((v & b64sd_pkg::MARK_INVALID) != 0) begin
                run_err = 1'b1;
            end else if ((v & b64sd_pkg::MARK_PAD) == 0) begin
                give_byte({a[5:0], b[5:4]});
                give_byte({b[3:0], c[5:2]});
                give_byte({c[1:0], d[5:0]});
            end else if (((a | b | c) & b64sd_pkg::MARK_PAD) == 0) begin
                give_byte({a[5:0], b[5:4]});
                give_byte({b[3:0], c[5:2]});
            end else if (((a | b) & b64sd_pkg::MARK_PAD) == 0 && c == d) begin
                give_byte({a[5:0], b[5:4]});
            end else begin
                run_err = 1'b1;
            end
        end
    endtask

    task automatic decode_item(input b64sd_pkg::t_in_item it);
        logic [7:0]           v;
        b64sd_pkg::t_out_item r;
        step_out.delete();
        if (!it.end_only) begin
            v = sextet_of(it.char_code);
            if (run_pos < 3) begin
                run_held[run_pos] = v;
                run_pos++;
            end else begin
                close_quantum(run_held[0], run_held[1], run_held[2], v);
                run_pos = 0;
            end
        end
        if (it.end_only || it.last_char) begin
            if (run_pos > 0)
                close_quantum(run_held[0],
                              run_pos > 1 ? run_held[1] : b64sd_pkg::MARK_PAD,
                              run_pos > 2 ? run_held[2] : b64sd_pkg::MARK_PAD,
                              b64sd_pkg::MARK_PAD);
            if (step_out.size() == 0) put_out(8'h00, 1'b0);
            r = step_out.pop_back();
            r.stream_done = 1'b1;
            r.status_code = run_err;
            r.total_len = run_err ? '0 : b64sd_pkg::sat_len(run_cnt);
            step_out.push_back(r);
            run_pos = 0;
            run_held = '{default: 8'h00};
            run_err = 1'b0;
            run_cnt = '0;
        end
        if (step_out.size() != 0) begin
            r = step_out.pop_back();
            r.run_last = 1'b1;
            step_out.push_back(r);
        end
    endtask

    task automatic offer(input b64sd_pkg::t_in_item it, input bit fixed,
                         input b64sd_pkg::t_out_item want);
        if (!quiet) begin
            while ($urandom_range(0, 99) < 26) begin
                push <= 1'b0;
                @(posedge i_clk);
            end
        end
        push <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (full);
        decode_item(it);
        if (fixed) owed_q.push_back(want);
        else foreach (step_out[k]) owed_q.push_back(step_out[k]);
        items_sent++;
    endtask

    task automatic check_out(input b64sd_pkg::t_out_item got);
        b64sd_pkg::t_out_item w;
        if (owed_q.size() == 0) begin
            $error("unexpected result item %p", got);
            err_cnt++;
        end else begin
            w = owed_q.pop_front();
            if (got.out_byte !== w.out_byte) begin
                $error("out_byte: expected %0h, got %0h", w.out_byte, got.out_byte);
                err_cnt++;
            end
            if (got.byte_valid !== w.byte_valid) begin
                $error("byte_valid: expected %0b, got %0b", w.byte_valid, got.byte_valid);
                err_cnt++;
            end
            if (got.stream_done !== w.stream_done) begin
                $error("stream_done: expected %0b, got %0b", w.stream_done, got.stream_done);
                err_cnt++;
            end
            if (got.status_code !== w.status_code) begin
                $error("status_code: expected %0b, got %0b", w.status_code, got.status_code);
                err_cnt++;
            end
            if (got.total_len !== w.total_len) begin
                $error("total_len: expected %0d, got %0d", w.total_len, got.total_len);
                err_cnt++;
            end
            if (got.run_last !== w.run_last) begin
                $error("run_last: expected %0b, got %0b", w.run_last, got.run_last);
                err_cnt++;
            end
        end
    endtask

    // leftover bits under a pad come out random, since every byte is random
    task automatic add_segment(input int nbytes, input bit padded);
        logic [7:0] b [3];
        logic [5:0] s [4];
        int         take;
        while (nbytes > 0) begin
            take = nbytes > 3 ? 3 : nbytes;
            for (int k = 0; k < 3; k++) b[k] = 8'($urandom);
            s[0] = b[0][7:2];
            s[1] = {b[0][1:0], b[1][7:4]};
            s[2] = {b[1][3:0], b[2][7:6]};
            s[3] = b[2][5:0];
            for (int k = 0; k <= take; k++) text_q.push_back(char_of(s[k]));
            if (padded) for (int k = take; k < 3; k++) text_q.push_back(b64sd_pkg::CH_EQ);
            nbytes -= take;
        end
    endtask

    task automatic build_text();
        int kind;
        int segs;
        int nb;
        int pos;
        text_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 85) begin
            segs = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
            for (int sg = 0; sg < segs; sg++) begin
                nb = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                 : $urandom_range(0, 7);
                add_segment(nb, (sg < segs - 1) || ($urandom_range(0, 1) == 1));
            end
            if (kind >= 70 && text_q.size() != 0) begin
                pos = $urandom_range(0, text_q.size() - 1);
                if ($urandom_range(0, 1) == 1) text_q[pos] = 8'($urandom);
                else text_q.insert(pos, b64sd_pkg::CH_EQ);
            end
        end else begin
            repeat ($urandom_range(1, 10)) text_q.push_back(8'($urandom));
        end
    endtask

    task automatic send_text();
        b64sd_pkg::t_in_item it;
        bit                  marker;
        marker = (text_q.size() == 0) || ($urandom_range(0, 1) == 1);
        foreach (text_q[k]) begin
            it.char_code = text_q[k];
            it.end_only = 1'b0;
            it.last_char = !marker && (k == text_q.size() - 1);
            offer(it, 1'b0, NO_FIX);
        end
        if (marker) begin
            it.char_code = 8'($urandom);
            it.end_only = 1'b1;
            it.last_char = 1'($urandom_range(0, 1));
            offer(it, 1'b0, NO_FIX);
        end
    endtask

    task automatic settle();
        while (owed_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [LEN_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cap_now = v;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) check_out(o_out_item);
        if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
            pop <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            pop <= 1'b0;
        end else begin
            pop <= quiet || ($urandom_range(0, 99) >= 26);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        logic [LEN_W-1:0] caps [NUM_PHASES];
        caps[0] = '0;
        caps[1] = LEN_W'(1);
        caps[2] = LEN_W'($urandom_range(2, 40));
        caps[3] = LEN_W'($urandom);
        caps[4] = b64sd_pkg::LEN_MAX;
        caps[5] = LEN_W'(5);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int r = 0; r < NUM_ROWS; r++)
            offer(DIR_TAB[r].it, DIR_TAB[r].fixed, DIR_TAB[r].want);
        push <= 1'b0;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            set_capacity(caps[ph]);
            if (ph == HOLD_PHASE) begin
                quiet <= 1'b1;
                hold_req <= 1'b1;
            end else begin
                quiet <= 1'b0;
            end
            items_sent = 0;
            while (items_sent < PHASE_ITEMS) begin
                build_text();
                send_text();
            end
            push <= 1'b0;
        end
        settle();
        if (err_cnt == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/b64sd_pkg.sv
design/b64sd_front.sv
design/b64sd_jobq.sv
design/b64sd_back.sv
design/base64_stream_decoder.sv
design/b64sd_checker.sv
tb/tb.sv
